// ===== design/tcme_pkg.sv =====
// Shared types, codes and byte constants for the terminal cursor-move encoder.
// Used by tcme_ctrl, tcme_dp and terminal_cursor_move_encoder; no dependencies.
`timescale 1ns / 1ps

package tcme_pkg;

    localparam int COORD_W   = 8;
    localparam int BUF_DEPTH = 10;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CFG_IDX_W = 3;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [7:0]         t_byte;

    localparam t_coord COORD_MAX = '1;

    typedef enum logic [1:0] {
        OP_PUTC   = 2'd0,
        OP_GOTO   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_FORGET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FAM_ANSI   = 2'd0,
        FAM_ESCY   = 2'd1,
        FAM_OFFSET = 2'd2,
        FAM_TILDE  = 2'd3
    } t_fam;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TSUB  = 3'd4;

    localparam t_byte ASC_BS     = 8'h08;
    localparam t_byte ASC_LF     = 8'h0A;
    localparam t_byte ASC_FF     = 8'h0C;
    localparam t_byte ASC_CR     = 8'h0D;
    localparam t_byte ASC_DC1    = 8'h11;
    localparam t_byte ASC_SUB    = 8'h1A;
    localparam t_byte ASC_FS     = 8'h1C;
    localparam t_byte ASC_ESC    = 8'h1B;
    localparam t_byte ASC_SPACE  = 8'h20;
    localparam t_byte ASC_ZERO   = 8'h30;
    localparam t_byte ASC_TWO    = 8'h32;
    localparam t_byte ASC_SEMI   = 8'h3B;
    localparam t_byte ASC_EQ     = 8'h3D;
    localparam t_byte ASC_C      = 8'h43;
    localparam t_byte ASC_H      = 8'h48;
    localparam t_byte ASC_J      = 8'h4A;
    localparam t_byte ASC_Y      = 8'h59;
    localparam t_byte ASC_LBRK   = 8'h5B;
    localparam t_byte ASC_CARET  = 8'h5E;
    localparam t_byte ASC_TILDE  = 8'h7E;
    localparam t_byte ASC_DEL    = 8'h7F;
    localparam t_byte ADDR_BIAS  = 8'd32;

    localparam logic [2:0] BS_MAX = 3'd6;
    localparam logic [2:0] LF_MAX = 3'd5;

    typedef struct packed {
        logic capture;
        logic plan;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_empty;
        logic slot_free;
        logic at_last;
    } t_dp_status;

    // d[0] is the most significant digit to send
    typedef struct packed {
        logic [1:0]      nd;
        logic [2:0][3:0] d;
    } t_dec;

    function automatic t_dec to_dec(input logic [COORD_W:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [13:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        t_dec        res;
        h    = (v >= 9'd200) ? 2'd2 : (v >= 9'd100) ? 2'd1 : 2'd0;
        r    = 7'(v - 9'(h) * 9'd100);
        prod = 14'(r) * 14'd103;
        t    = 4'(prod >> 10);
        o    = 4'(r - 7'(t) * 7'd10);
        res  = '0;
        if (h != 2'd0) begin
            res.nd   = 2'd3;
            res.d[0] = 4'(h);
            res.d[1] = t;
            res.d[2] = o;
        end else if (t != 4'd0) begin
            res.nd   = 2'd2;
            res.d[0] = t;
            res.d[1] = o;
        end else begin
            res.nd   = 2'd1;
            res.d[0] = o;
        end
        return res;
    endfunction

endpackage

// ===== design/terminal_cursor_move_encoder.sv =====
// Top level of the terminal cursor-move encoder: ports, controller and datapath.
// Depends on tcme_pkg, tcme_ctrl and tcme_dp.
`timescale 1ns / 1ps

// Usage:
//   Input words arrive on s_axis: tuser carries the request kind (put character,
//   go to position, clear screen, forget position), tdata carries the character
//   and the target row and column. Each request yields zero to ten bytes on
//   m_axis, one byte per word, with tlast on the final byte of the request.
//   Requests that send nothing (already in place, forget) give no output word.
//   Settings are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Timing:
//   After a word is taken, the PLAN state plans the byte sequence; in the EMIT
//   state the bytes then enter the output register one per cycle while the
//   output register is free or being read. The input stays not ready until the
//   controller has issued the last byte of the request, or until planning ends
//   when nothing is sent. The last byte may still wait in the output register
//   while the next word is accepted.
// Reset and stall:
//   Reset (i_rst_n low, synchronous) restores 24 rows, 80 columns, the ANSI
//   family, no wrap drop, no tilde substitution, and marks the cursor unknown.
//   When m_axis_tready is low a valid byte holds and sequencing pauses behind it.

module terminal_cursor_move_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // char_byte, target_row, target_col
    input  logic [1:0]                       s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // out_byte
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [tcme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                       i_cfg_data
);

    tcme_pkg::t_dp_cmd    w_cmd;
    tcme_pkg::t_dp_status w_status;

    tcme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tcme_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_char      (s_axis_tdata[7:0]),
        .i_row       (s_axis_tdata[15:8]),
        .i_col       (s_axis_tdata[23:16]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ===== design/tcme_ctrl.sv =====
// Sequencing state machine of the cursor-move encoder: capture, plan, emit.
// Depends on tcme_pkg; drives tcme_dp through command and status structs.
`timescale 1ns / 1ps

module tcme_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcme_pkg::t_dp_status i_status,
    output tcme_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    assign o_in_ready    = r_in_ready;
    assign o_cmd.capture = r_in_ready & i_in_valid;
    assign o_cmd.plan    = (r_state == ST_PLAN);
    assign o_cmd.advance = (r_state == ST_EMIT) & i_status.slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state    <= ST_PLAN;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_PLAN: begin
                    if (i_status.plan_empty) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (o_cmd.advance && i_status.at_last) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/tcme_dp.sv =====
// Datapath of the cursor-move encoder: settings, cursor shadow, byte plan, output word.
// Depends on tcme_pkg; commanded by tcme_ctrl.
`timescale 1ns / 1ps

module tcme_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcme_pkg::t_dp_cmd                i_cmd,
    output tcme_pkg::t_dp_status             o_status,
    input  logic                             i_cfg_we,
    input  logic [tcme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                       i_cfg_data,
    input  logic [1:0]                       i_op,
    input  tcme_pkg::t_byte                  i_char,
    input  tcme_pkg::t_coord                 i_row,
    input  tcme_pkg::t_coord                 i_col,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output tcme_pkg::t_byte                  o_out_byte,
    output logic                             o_out_last
);

    logic [7:0]        r_rows;
    logic [7:0]        r_cols;
    tcme_pkg::t_fam    r_fam;
    logic              r_wrap;
    logic              r_tsub;

    tcme_pkg::t_op     r_op;
    tcme_pkg::t_byte   r_chr;
    tcme_pkg::t_coord  r_row;
    tcme_pkg::t_coord  r_col;
    tcme_pkg::t_dec    r_rdec;
    tcme_pkg::t_dec    r_cdec;

    tcme_pkg::t_coord  r_trow;
    tcme_pkg::t_coord  r_tcol;
    logic              r_trow_v;
    logic              r_tcol_v;
    tcme_pkg::t_coord  n_trow;
    tcme_pkg::t_coord  n_tcol;
    logic              n_trow_v;
    logic              n_tcol_v;

    tcme_pkg::t_byte   r_buf [tcme_pkg::BUF_DEPTH];
    tcme_pkg::t_byte   n_buf [tcme_pkg::BUF_DEPTH];
    logic [tcme_pkg::CNT_W-1:0] r_cnt;
    logic [tcme_pkg::CNT_W-1:0] n_cnt;
    logic [tcme_pkg::IDX_W-1:0] r_idx;

    logic              r_out_valid;
    tcme_pkg::t_byte   r_out_byte;
    logic              r_out_last;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    assign o_status.plan_empty = (n_cnt == '0);
    assign o_status.slot_free  = !r_out_valid || i_out_ready;
    assign o_status.at_last    = (tcme_pkg::CNT_W'(r_idx) == r_cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'd24;
            r_cols <= 8'd80;
            r_fam  <= tcme_pkg::FAM_ANSI;
            r_wrap <= 1'b0;
            r_tsub <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcme_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                tcme_pkg::CFG_COLS: r_cols <= i_cfg_data;
                tcme_pkg::CFG_FAM:  r_fam  <= tcme_pkg::t_fam'(i_cfg_data[1:0]);
                tcme_pkg::CFG_WRAP: r_wrap <= i_cfg_data[0];
                tcme_pkg::CFG_TSUB: r_tsub <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= tcme_pkg::t_op'(i_op);
            r_chr  <= i_char;
            r_row  <= i_row;
            r_col  <= i_col;
            r_rdec <= tcme_pkg::to_dec({1'b0, i_row} + 1'b1);
            r_cdec <= tcme_pkg::to_dec({1'b0, i_col} + 1'b1);
        end
    end

    always_comb begin : plan
        tcme_pkg::t_byte          c;
        tcme_pkg::t_coord         col_inc;
        tcme_pkg::t_coord         dr;
        tcme_pkg::t_coord         dbs;
        tcme_pkg::t_coord         dfw;
        tcme_pkg::t_coord         lim;
        logic                     known;
        logic                     same_row;
        logic [tcme_pkg::IDX_W-1:0] p;

        c        = (r_tsub && r_chr == tcme_pkg::ASC_TILDE) ? tcme_pkg::ASC_CARET : r_chr;
        col_inc  = (r_tcol != tcme_pkg::COORD_MAX) ? r_tcol + 1'b1 : r_tcol;
        dr       = r_row - r_trow;
        dbs      = r_tcol - r_col;
        dfw      = r_col - r_tcol;
        known    = r_trow_v && r_tcol_v;
        same_row = known && (r_row == r_trow);
        p        = '0;
        case (r_fam)
            tcme_pkg::FAM_ANSI:   lim = 8'd2;
            tcme_pkg::FAM_ESCY:   lim = 8'd3;
            tcme_pkg::FAM_OFFSET: lim = 8'd6;
            default:              lim = 8'd0;
        endcase

        for (int i = 0; i < tcme_pkg::BUF_DEPTH; i++) n_buf[i] = '0;
        n_cnt    = '0;
        n_trow   = r_trow;
        n_tcol   = r_tcol;
        n_trow_v = r_trow_v;
        n_tcol_v = r_tcol_v;

        case (r_op)
            tcme_pkg::OP_PUTC: begin
                n_buf[0] = c;
                n_cnt    = tcme_pkg::CNT_W'(1);
                if (c >= tcme_pkg::ASC_SPACE && c != tcme_pkg::ASC_DEL) begin
                    if (r_tcol_v) begin
                        n_tcol = col_inc;
                        if (r_wrap && col_inc >= r_cols) begin
                            n_trow_v = 1'b0;
                            n_tcol_v = 1'b0;
                        end
                    end
                end else if (c == tcme_pkg::ASC_CR) begin
                    n_tcol   = '0;
                    n_tcol_v = 1'b1;
                end else if (c == tcme_pkg::ASC_LF) begin
                    if (r_trow_v && r_trow != tcme_pkg::COORD_MAX) n_trow = r_trow + 1'b1;
                    n_tcol   = '0;
                    n_tcol_v = 1'b1;
                end else if (c == tcme_pkg::ASC_BS) begin
                    if (r_tcol_v && r_tcol != '0) n_tcol = r_tcol - 1'b1;
                end else begin
                    n_trow_v = 1'b0;
                    n_tcol_v = 1'b0;
                end
            end
            tcme_pkg::OP_GOTO: begin
                n_trow   = r_row;
                n_tcol   = r_col;
                n_trow_v = 1'b1;
                n_tcol_v = 1'b1;
                if (same_row && r_col == r_tcol) begin
                    n_cnt = '0;
                end else if (same_row && r_col == '0) begin
                    n_buf[0] = tcme_pkg::ASC_CR;
                    n_cnt    = tcme_pkg::CNT_W'(1);
                end else if (same_row && r_col < r_tcol && dbs <= 8'(tcme_pkg::BS_MAX)) begin
                    for (int i = 0; i < 6; i++) begin
                        if (8'(i) < dbs) n_buf[i] = tcme_pkg::ASC_BS;
                    end
                    n_cnt = tcme_pkg::CNT_W'(dbs);
                end else if (same_row && r_col > r_tcol && dfw <= lim) begin
                    case (r_fam)
                        tcme_pkg::FAM_ANSI: begin
                            for (int i = 0; i < 2; i++) begin
                                if (8'(i) < dfw) begin
                                    n_buf[3*i]   = tcme_pkg::ASC_ESC;
                                    n_buf[3*i+1] = tcme_pkg::ASC_LBRK;
                                    n_buf[3*i+2] = tcme_pkg::ASC_C;
                                end
                            end
                            n_cnt = tcme_pkg::CNT_W'(dfw * 8'd3);
                        end
                        tcme_pkg::FAM_ESCY: begin
                            for (int i = 0; i < 3; i++) begin
                                if (8'(i) < dfw) begin
                                    n_buf[2*i]   = tcme_pkg::ASC_ESC;
                                    n_buf[2*i+1] = tcme_pkg::ASC_C;
                                end
                            end
                            n_cnt = tcme_pkg::CNT_W'(dfw * 8'd2);
                        end
                        default: begin
                            for (int i = 0; i < 6; i++) begin
                                if (8'(i) < dfw) n_buf[i] = tcme_pkg::ASC_FF;
                            end
                            n_cnt = tcme_pkg::CNT_W'(dfw);
                        end
                    endcase
                end else if (known && r_col == '0 && r_row > r_trow
                             && dr <= 8'(tcme_pkg::LF_MAX)
                             && ({1'b0, r_row} + 9'd2) <= {1'b0, r_rows}) begin
                    if (r_tcol != '0) begin
                        n_buf[0] = tcme_pkg::ASC_CR;
                        for (int i = 0; i < 5; i++) begin
                            if (8'(i) < dr) n_buf[i+1] = tcme_pkg::ASC_LF;
                        end
                        n_cnt = tcme_pkg::CNT_W'(dr + 8'd1);
                    end else begin
                        for (int i = 0; i < 5; i++) begin
                            if (8'(i) < dr) n_buf[i] = tcme_pkg::ASC_LF;
                        end
                        n_cnt = tcme_pkg::CNT_W'(dr);
                    end
                end else begin
                    case (r_fam)
                        tcme_pkg::FAM_ANSI: begin
                            n_buf[0] = tcme_pkg::ASC_ESC;
                            n_buf[1] = tcme_pkg::ASC_LBRK;
                            p        = tcme_pkg::IDX_W'(2);
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < r_rdec.nd) begin
                                    n_buf[p] = tcme_pkg::ASC_ZERO | 8'(r_rdec.d[k]);
                                    p        = p + 1'b1;
                                end
                            end
                            n_buf[p] = tcme_pkg::ASC_SEMI;
                            p        = p + 1'b1;
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < r_cdec.nd) begin
                                    n_buf[p] = tcme_pkg::ASC_ZERO | 8'(r_cdec.d[k]);
                                    p        = p + 1'b1;
                                end
                            end
                            n_buf[p] = tcme_pkg::ASC_H;
                            n_cnt    = tcme_pkg::CNT_W'(p) + 1'b1;
                        end
                        tcme_pkg::FAM_ESCY, tcme_pkg::FAM_OFFSET: begin
                            n_buf[0] = tcme_pkg::ASC_ESC;
                            n_buf[1] = (r_fam == tcme_pkg::FAM_ESCY) ? tcme_pkg::ASC_Y
                                                                     : tcme_pkg::ASC_EQ;
                            n_buf[2] = r_row + tcme_pkg::ADDR_BIAS;
                            n_buf[3] = r_col + tcme_pkg::ADDR_BIAS;
                            n_cnt    = tcme_pkg::CNT_W'(4);
                        end
                        default: begin
                            n_buf[0] = tcme_pkg::ASC_TILDE;
                            n_buf[1] = tcme_pkg::ASC_DC1;
                            n_buf[2] = r_col;
                            n_buf[3] = r_row;
                            n_cnt    = tcme_pkg::CNT_W'(4);
                        end
                    endcase
                end
            end
            tcme_pkg::OP_CLEAR: begin
                n_trow   = '0;
                n_tcol   = '0;
                n_trow_v = 1'b1;
                n_tcol_v = 1'b1;
                case (r_fam)
                    tcme_pkg::FAM_ANSI: begin
                        n_buf[0] = tcme_pkg::ASC_ESC;
                        n_buf[1] = tcme_pkg::ASC_LBRK;
                        n_buf[2] = tcme_pkg::ASC_TWO;
                        n_buf[3] = tcme_pkg::ASC_J;
                        n_buf[4] = tcme_pkg::ASC_ESC;
                        n_buf[5] = tcme_pkg::ASC_LBRK;
                        n_buf[6] = tcme_pkg::ASC_H;
                        n_cnt    = tcme_pkg::CNT_W'(7);
                    end
                    tcme_pkg::FAM_ESCY: begin
                        n_buf[0] = tcme_pkg::ASC_ESC;
                        n_buf[1] = tcme_pkg::ASC_H;
                        n_buf[2] = tcme_pkg::ASC_ESC;
                        n_buf[3] = tcme_pkg::ASC_J;
                        n_cnt    = tcme_pkg::CNT_W'(4);
                    end
                    tcme_pkg::FAM_OFFSET: begin
                        n_buf[0] = tcme_pkg::ASC_SUB;
                        n_cnt    = tcme_pkg::CNT_W'(1);
                    end
                    default: begin
                        n_buf[0] = tcme_pkg::ASC_TILDE;
                        n_buf[1] = tcme_pkg::ASC_FS;
                        n_cnt    = tcme_pkg::CNT_W'(2);
                    end
                endcase
            end
            default: begin
                n_trow_v = 1'b0;
                n_tcol_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trow_v <= 1'b0;
            r_tcol_v <= 1'b0;
        end else if (i_cmd.plan) begin
            r_trow_v <= n_trow_v;
            r_tcol_v <= n_tcol_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.plan) begin
            r_trow <= n_trow;
            r_tcol <= n_tcol;
            r_buf  <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_cmd.plan) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_out_byte <= r_buf[r_idx];
            r_out_last <= o_status.at_last;
        end
    end

endmodule

// ===== verif/terminal_cursor_move_encoder_tb.sv =====
// Self-checking testbench for terminal_cursor_move_encoder: drives requests and settings,
// predicts the byte stream with a scoreboard class and checks every output word.
// Depends on tcme_pkg and the terminal_cursor_move_encoder RTL.
`timescale 1ns / 1ps

module terminal_cursor_move_encoder_tb;

    import tcme_pkg::*;

    typedef struct {
        t_byte b;
        bit    last;
    } t_due_byte;

    class cursor_scoreboard;
        int        rows;
        int        cols;
        t_fam      fam;
        bit        wrap;
        bit        tsub;
        int        cur_row;
        int        cur_col;
        int        mismatches;
        t_due_byte bytes_due[$];

        function new();
            rows       = 24;
            cols       = 80;
            fam        = FAM_ANSI;
            wrap       = 1'b0;
            tsub       = 1'b0;
            mismatches = 0;
            forget_pos();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return bytes_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, t_byte data);
            case (idx)
                CFG_ROWS: rows = int'(data);
                CFG_COLS: cols = int'(data);
                CFG_FAM:  fam  = t_fam'(data[1:0]);
                CFG_WRAP: wrap = data[0];
                CFG_TSUB: tsub = data[0];
                default: ;
            endcase
        endfunction

        function void add_byte(t_byte b);
            t_due_byte e;
            e.b    = b;
            e.last = 1'b0;
            bytes_due.push_back(e);
        endfunction

        function void add_decimal(int n);
            if (n >= 100) add_byte(ASC_ZERO + t_byte'(n / 100));
            if (n >= 10) add_byte(ASC_ZERO + t_byte'((n / 10) % 10));
            add_byte(ASC_ZERO + t_byte'(n % 10));
        endfunction

        function void forget_pos();
            cur_row = -1;
            cur_col = -1;
        endfunction

        function void print_char(t_byte ch);
            t_byte c;
            c = ch;
            if (tsub && c == ASC_TILDE) c = ASC_CARET;
            add_byte(c);
            if (c >= ASC_SPACE && c != ASC_DEL) begin
                if (cur_col >= 0) begin
                    if (cur_col < int'(COORD_MAX)) cur_col++;
                    if (wrap && cur_col >= cols) forget_pos();
                end
            end else if (c == ASC_CR) begin
                cur_col = 0;
            end else if (c == ASC_LF) begin
                if (cur_row >= 0 && cur_row < int'(COORD_MAX)) cur_row++;
                cur_col = 0;
            end else if (c == ASC_BS) begin
                if (cur_col > 0) cur_col--;
            end else begin
                forget_pos();
            end
        endfunction

        function void move_to(int row, int col);
            int dr;
            int lim;
            if (row == cur_row && col == cur_col) return;
            if (cur_row >= 0 && cur_col >= 0) begin
                dr = row - cur_row;
                if (dr == 0) begin
                    if (col == 0) begin
                        add_byte(ASC_CR);
                        cur_col = 0;
                        return;
                    end
                    if (col < cur_col && cur_col - col <= int'(BS_MAX)) begin
                        repeat (cur_col - col) add_byte(ASC_BS);
                        cur_col = col;
                        return;
                    end
                    case (fam)
                        FAM_ANSI:   lim = 2;
                        FAM_ESCY:   lim = 3;
                        FAM_OFFSET: lim = 6;
                        default:    lim = 0;
                    endcase
                    if (col > cur_col && col - cur_col <= lim) begin
                        repeat (col - cur_col) begin
                            case (fam)
                                FAM_ANSI: begin
                                    add_byte(ASC_ESC);
                                    add_byte(ASC_LBRK);
                                    add_byte(ASC_C);
                                end
                                FAM_ESCY: begin
                                    add_byte(ASC_ESC);
                                    add_byte(ASC_C);
                                end
                                default: add_byte(ASC_FF);
                            endcase
                        end
                        cur_col = col;
                        return;
                    end
                end
                if (col == 0 && dr > 0 && dr <= int'(LF_MAX) && row <= rows - 2) begin
                    if (cur_col != 0) add_byte(ASC_CR);
                    repeat (dr) add_byte(ASC_LF);
                    cur_row = row;
                    cur_col = 0;
                    return;
                end
            end
            case (fam)
                FAM_ANSI: begin
                    add_byte(ASC_ESC);
                    add_byte(ASC_LBRK);
                    add_decimal(row + 1);
                    add_byte(ASC_SEMI);
                    add_decimal(col + 1);
                    add_byte(ASC_H);
                end
                FAM_ESCY, FAM_OFFSET: begin
                    add_byte(ASC_ESC);
                    add_byte(fam == FAM_ESCY ? ASC_Y : ASC_EQ);
                    add_byte(t_byte'(row) + ADDR_BIAS);
                    add_byte(t_byte'(col) + ADDR_BIAS);
                end
                default: begin
                    add_byte(ASC_TILDE);
                    add_byte(ASC_DC1);
                    add_byte(t_byte'(col));
                    add_byte(t_byte'(row));
                end
            endcase
            cur_row = row;
            cur_col = col;
        endfunction

        function void clear_screen();
            case (fam)
                FAM_ANSI: begin
                    add_byte(ASC_ESC);
                    add_byte(ASC_LBRK);
                    add_byte(ASC_TWO);
                    add_byte(ASC_J);
                    add_byte(ASC_ESC);
                    add_byte(ASC_LBRK);
                    add_byte(ASC_H);
                end
                FAM_ESCY: begin
                    add_byte(ASC_ESC);
                    add_byte(ASC_H);
                    add_byte(ASC_ESC);
                    add_byte(ASC_J);
                end
                FAM_OFFSET: add_byte(ASC_SUB);
                default: begin
                    add_byte(ASC_TILDE);
                    add_byte(ASC_FS);
                end
            endcase
            cur_row = 0;
            cur_col = 0;
        endfunction

        function void note_request(t_op op, t_byte ch, int row, int col);
            int n0;
            n0 = bytes_due.size();
            case (op)
                OP_PUTC:  print_char(ch);
                OP_GOTO:  move_to(row, col);
                OP_CLEAR: clear_screen();
                default:  forget_pos();
            endcase
            if (bytes_due.size() > n0) bytes_due[bytes_due.size() - 1].last = 1'b1;
        endfunction

        task check_byte(t_byte b, logic last);
            t_due_byte e;
            if (bytes_due.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", b, last));
                return;
            end
            e = bytes_due.pop_front();
            if (b !== e.b) report($sformatf("byte %02h, expected %02h", b, e.b));
            if (last !== e.last) report($sformatf("last %0b on byte %02h, expected %0b",
                                                  last, b, e.last));
        endtask
    endclass

    localparam int   PH_ROWS [8] = '{24, 255, 2, 30, 2, 100, 255, 8};
    localparam int   PH_COLS [8] = '{80, 255, 1, 40, 0, 255, 132, 20};
    localparam t_fam PH_FAM  [8] = '{FAM_ESCY, FAM_OFFSET, FAM_TILDE, FAM_ANSI,
                                     FAM_ESCY, FAM_TILDE, FAM_OFFSET, FAM_ANSI};
    localparam bit   PH_WRAP [8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam bit   PH_TSUB [8] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]           i_cfg_data = '0;

    cursor_scoreboard sb;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;
    int               hold_cnt = 0;

    terminal_cursor_move_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hold tready low while hold_cnt counts down, otherwise stall at random
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_word(input t_op op, input t_byte ch, input t_coord row, input t_coord col);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {col, row, ch};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, ch, int'(row), int'(col));
    endtask

    task automatic send_random(input int count);
        int    k;
        int    pick;
        int    r;
        int    c;
        t_byte ch;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            ch   = t_byte'($urandom);
            r    = $urandom_range(255);
            c    = $urandom_range(255);
            if (pick < 40) begin
                case ($urandom_range(11))
                    0: ch = ASC_CR;
                    1: ch = ASC_LF;
                    2: ch = ASC_BS;
                    3: ch = ASC_TILDE;
                    4: ch = t_byte'($urandom_range(31));
                    5: ch = ASC_DEL;
                    6, 7: ;
                    default: ch = t_byte'($urandom_range(8'h20, 8'h7E));
                endcase
                send_word(OP_PUTC, ch, t_coord'(r), t_coord'(c));
            end else if (pick < 80) begin
                if (sb.cur_row >= 0 && sb.cur_col >= 0 && $urandom_range(4) != 0) begin
                    case ($urandom_range(3))
                        0: begin
                            r = sb.cur_row;
                            c = sb.cur_col + $urandom_range(14) - 7;
                        end
                        1: begin
                            r = sb.cur_row + $urandom_range(1, 6);
                            c = 0;
                        end
                        2: begin
                            r = sb.cur_row;
                            c = $urandom_range(1) ? 0 : sb.cur_col;
                        end
                        default: begin
                            r = $urandom_range(sb.rows);
                            c = $urandom_range(sb.cols);
                        end
                    endcase
                end else if ($urandom_range(1)) begin
                    r = $urandom_range(sb.rows);
                    c = $urandom_range(sb.cols);
                end
                if (r < 0) r = 0;
                if (r > 255) r = 255;
                if (c < 0) c = 0;
                if (c > 255) c = 255;
                send_word(OP_GOTO, ch, t_coord'(r), t_coord'(c));
            end else if (pick < 90) begin
                send_word(OP_CLEAR, ch, t_coord'(r), t_coord'(c));
            end else begin
                send_word(OP_FORGET, ch, t_coord'(r), t_coord'(c));
            end
        end
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input int rows, input int cols, input t_fam fam,
                             input bit wrap, input bit tsub);
        write_reg(CFG_ROWS, t_byte'(rows));
        write_reg(CFG_COLS, t_byte'(cols));
        write_reg(CFG_FAM, t_byte'(fam));
        write_reg(CFG_WRAP, t_byte'(wrap));
        write_reg(CFG_TSUB, t_byte'(tsub));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int ph;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 30;
        snk_idle_pct = 74;

        send_word(OP_GOTO, 8'h00, 8'd0, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd0, 8'd0);
        send_word(OP_PUTC, 8'h41, 8'd0, 8'd0);
        send_word(OP_PUTC, ASC_TILDE, 8'd0, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd0, 8'd5);
        send_word(OP_GOTO, 8'h00, 8'd0, 8'd7);
        send_word(OP_GOTO, 8'h00, 8'd0, 8'd1);
        send_word(OP_GOTO, 8'h00, 8'd0, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd5, 8'd0);
        send_word(OP_PUTC, 8'h78, 8'd0, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd8, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd21, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd22, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd23, 8'd0);
        send_word(OP_GOTO, 8'hFF, 8'd255, 8'd255);
        send_word(OP_PUTC, 8'h5A, 8'd0, 8'd0);
        send_word(OP_GOTO, 8'h00, 8'd255, 8'd255);
        send_word(OP_PUTC, ASC_LF, 8'd0, 8'd0);
        send_word(OP_PUTC, ASC_BS, 8'd0, 8'd0);
        send_word(OP_PUTC, ASC_DEL, 8'd0, 8'd0);
        send_word(OP_CLEAR, 8'h00, 8'd0, 8'd0);
        send_word(OP_PUTC, 8'h00, 8'd0, 8'd0);
        send_word(OP_FORGET, 8'h00, 8'd0, 8'd0);
        send_word(OP_PUTC, 8'hFF, 8'd0, 8'd0);
        send_random(18);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 2) begin
                src_idle_pct = 74;
                snk_idle_pct = 30;
            end
            if (ph == 5) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            configure(PH_ROWS[ph], PH_COLS[ph], PH_FAM[ph], PH_WRAP[ph], PH_TSUB[ph]);
            if (ph == 2) begin
                send_word(OP_CLEAR, 8'h00, 8'd0, 8'd0);
                send_word(OP_PUTC, ASC_TILDE, 8'd0, 8'd0);
                send_word(OP_GOTO, 8'h00, 8'd0, 8'd0);
            end
            if (ph == 6) hold_cnt <= 200;
            send_random(28);
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcme_pkg.sv
design/tcme_ctrl.sv
design/tcme_dp.sv
design/terminal_cursor_move_encoder.sv
verif/terminal_cursor_move_encoder_tb.sv
